>>> design/tiny_accumulator_cpu_step_macros.svh
// Assertion helpers used by the checker file.
`ifndef TINY_ACCUMULATOR_CPU_STEP_MACROS_SVH
`define TINY_ACCUMULATOR_CPU_STEP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define TAC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define TAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/tac_pkg.sv
package tac_pkg;

  localparam int unsigned PROG_DEPTH = 128;
  localparam int unsigned DATA_DEPTH = 128;
  localparam int unsigned PROG_AW    = $clog2(PROG_DEPTH);
  localparam int unsigned DATA_AW    = $clog2(DATA_DEPTH);

  // item kinds
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EXEC  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ADDR  = 2'd1,
    ST_BADOP = 2'd2,
    ST_HALT  = 2'd3
  } status_e;

  // opcodes, high nibble of the instruction byte
  localparam logic [3:0] OPC_LOAD  = 4'h0;
  localparam logic [3:0] OPC_STORE = 4'h2;
  localparam logic [3:0] OPC_MOVE  = 4'h4;
  localparam logic [3:0] OPC_IMM   = 4'h5;
  localparam logic [3:0] OPC_ADD   = 4'h6;
  localparam logic [3:0] OPC_SUB   = 4'h7;
  localparam logic [3:0] OPC_SHL   = 4'h8;
  localparam logic [3:0] OPC_SHR   = 4'h9;
  localparam logic [3:0] OPC_TEST  = 4'hA;
  localparam logic [3:0] OPC_OUT   = 4'hC;
  localparam logic [3:0] OPC_IN    = 4'hD;
  localparam logic [3:0] OPC_BEQ   = 4'hE;
  localparam logic [3:0] OPC_JUMP  = 4'hF;

  localparam logic [7:0] HALT_BYTE = 8'hFF;

  typedef struct packed {
    logic       op;
    logic [6:0] prog_address;
    logic [7:0] prog_data;
    logic [7:0] io_in;
  } in_item_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] next_pc;
    logic       zero_flag;
    logic       overflow_flag;
    logic       out_valid;
    logic [7:0] out_value;
    logic       in_taken;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic fetch;
    logic prog_we;
    logic mem_rd;
    logic commit_ex;
    logic commit_wr;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_mem;
  } stat_t;

endpackage

>>> design/tiny_accumulator_cpu_step.sv
// Small 8-bit accumulator CPU, one instruction per execute item.
// Input channel (in_valid_i / in_stall_o / in_data_i): each transfer is either
//   a program byte write (op = 0) or a request to run one instruction (op = 1).
// Output channel (out_valid_o / out_stall_i / out_data_o): exactly one result
//   per input transfer, in order: status, pc and flags after the item, plus
//   the output-port byte and input-taken bit of that instruction.
// Sequence: a write item goes through the write state and a non-load
//   instruction through execute before the next item can be taken. A load
//   goes through execute, then load writeback, since the program store
//   read and the data store read are two registered memory accesses in turn.
// A new item is taken while the previous result still waits in the output
//   register. If the receiver stalls, the item in flight holds before its
//   commit until the output register frees, and in_stall_o stays high.
// Reset clears pc, registers, flags and the halt state at once, and both
//   stores read as zero through per-entry valid flops; no clearing pass.
// A halt byte or running past the program store halts the core; every later
//   execute item reports halted until reset.
module tiny_accumulator_cpu_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tac_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tac_pkg::out_item_t out_data_o
);

  tac_pkg::cmd_t  cmd;   // sequencing commands
  tac_pkg::stat_t stat;  // decode status back to the sequencer

  // sequencer: idle / write result / execute / load writeback
  tac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_op_i     (in_data_i.op),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // registers, flags, pc, both stores and the result register
  tac_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .res_o     (out_data_o)
  );

endmodule

>>> design/tac_ctrl.sv
module tac_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          in_op_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tac_pkg::cmd_t cmd_o,
  input  tac_pkg::stat_t stat_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WRITE,
    S_EXEC,
    S_LOAD
  } state_e;

  state_e state_q;
  logic   res_valid_q;
  logic   accept;
  logic   out_free;
  logic   commit;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !res_valid_q || !out_stall_i;
  assign out_valid_o = res_valid_q;

  always_comb begin
    cmd_o.fetch     = accept && (in_op_i == tac_pkg::OP_EXEC);
    cmd_o.prog_we   = accept && (in_op_i == tac_pkg::OP_WRITE);
    cmd_o.mem_rd    = (state_q == S_EXEC) && stat_i.need_mem;
    cmd_o.commit_ex = out_free &&
                      (((state_q == S_EXEC) && !stat_i.need_mem) || (state_q == S_LOAD));
    cmd_o.commit_wr = out_free && (state_q == S_WRITE);
  end

  assign commit = cmd_o.commit_ex || cmd_o.commit_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        res_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_o.fetch) begin
            state_q <= S_EXEC;
          end else if (cmd_o.prog_we) begin
            state_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (out_free) state_q <= S_IDLE;
        end
        S_EXEC: begin
          if (stat_i.need_mem) begin
            state_q <= S_LOAD;
          end else if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        S_LOAD: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/tac_dp.sv
module tac_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tac_pkg::in_item_t  in_data_i,
  input  tac_pkg::cmd_t      cmd_i,
  output tac_pkg::stat_t     stat_o,
  output tac_pkg::out_item_t res_o
);

  localparam int unsigned PAW = tac_pkg::PROG_AW;
  localparam int unsigned DAW = tac_pkg::DATA_AW;

  // architectural state
  logic [7:0] regs_q [4];
  logic [7:0] regs_d [4];
  logic [7:0] pc_q, pc_d;
  logic       z_q, z_d;
  logic       v_q, v_d;
  logic       halted_q, halted_d;

  // stores, each entry reads as zero until written
  logic [7:0]            prog_mem [tac_pkg::PROG_DEPTH];
  logic [7:0]            data_mem [tac_pkg::DATA_DEPTH];
  logic [tac_pkg::PROG_DEPTH-1:0] prog_vld_q;
  logic [tac_pkg::DATA_DEPTH-1:0] data_vld_q;

  logic [7:0] ins_q;
  logic [7:0] io_q;
  logic [7:0] ld_q;
  tac_pkg::out_item_t res_q;

  logic [8:0]     wa_ext;
  logic           wa_ok;
  logic [PAW-1:0] wa;
  logic [PAW-1:0] fa;
  logic [DAW-1:0] da;
  logic           pc_oob;
  logic           da_oob;

  logic [3:0] opc;
  logic [1:0] dd;
  logic [1:0] yy;
  logic [7:0] ra;
  logic [7:0] ry;
  logic [8:0] sum;
  logic [7:0] diff;

  tac_pkg::status_e status_d;
  logic             outv_d;
  logic [7:0]       outval_d;
  logic             intk_d;
  logic             dwe_d;
  logic             need_mem;

  assign wa_ext = 9'(in_data_i.prog_address);
  assign wa_ok  = wa_ext < 9'(tac_pkg::PROG_DEPTH);
  assign wa     = wa_ext[PAW-1:0];
  assign fa     = pc_q[PAW-1:0];

  assign opc  = ins_q[7:4];
  assign dd   = ins_q[3:2];
  assign yy   = ins_q[1:0];
  assign ra   = regs_q[dd];
  assign ry   = regs_q[yy];
  assign da   = ra[DAW-1:0];
  assign sum  = {1'b0, ra} + {1'b0, ry};
  assign diff = ra - ry;

  assign pc_oob = {1'b0, pc_q} >= 9'(tac_pkg::PROG_DEPTH);
  assign da_oob = {1'b0, ra} >= 9'(tac_pkg::DATA_DEPTH);

  // instruction execute; load writes back the data read registered in the execute state
  always_comb begin
    regs_d   = regs_q;
    pc_d     = pc_q;
    z_d      = z_q;
    v_d      = v_q;
    halted_d = halted_q;
    status_d = tac_pkg::ST_OK;
    outv_d   = 1'b0;
    outval_d = '0;
    intk_d   = 1'b0;
    dwe_d    = 1'b0;
    need_mem = 1'b0;
    if (halted_q) begin
      status_d = tac_pkg::ST_HALT;
    end else if (pc_oob) begin
      halted_d = 1'b1;
      status_d = tac_pkg::ST_HALT;
    end else begin
      pc_d = pc_q + 8'd1;
      if (ins_q == tac_pkg::HALT_BYTE) begin
        halted_d = 1'b1;
        status_d = tac_pkg::ST_HALT;
      end else begin
        unique case (opc)
          tac_pkg::OPC_LOAD: begin
            if (da_oob) begin
              status_d = tac_pkg::ST_ADDR;
            end else begin
              need_mem  = 1'b1;
              regs_d[0] = ld_q;
              z_d       = (ld_q == 8'd0);
            end
          end
          tac_pkg::OPC_STORE: begin
            if (da_oob) begin
              status_d = tac_pkg::ST_ADDR;
            end else begin
              dwe_d = 1'b1;
              z_d   = (regs_q[0] == 8'd0);
            end
          end
          tac_pkg::OPC_MOVE: begin
            regs_d[yy] = ra;
            z_d        = (ra == 8'd0);
          end
          tac_pkg::OPC_IMM: begin
            regs_d[0] = {4'd0, ins_q[3:0]};
            z_d       = (ins_q[3:0] == 4'd0);
          end
          tac_pkg::OPC_ADD: begin
            regs_d[dd] = sum[7:0];
            v_d        = sum[8];
            z_d        = (sum[7:0] == 8'd0);
          end
          tac_pkg::OPC_SUB: begin
            regs_d[dd] = diff;
            v_d        = (ra[7] ^ ry[7]) & (diff[7] ^ ra[7]);
            z_d        = (diff == 8'd0);
          end
          tac_pkg::OPC_SHL:  regs_d[dd] = {ra[3:0], 4'd0};
          tac_pkg::OPC_SHR:  regs_d[dd] = {4'd0, ra[7:4]};
          tac_pkg::OPC_TEST: z_d = (ra == 8'd0);
          tac_pkg::OPC_OUT: begin
            outv_d   = 1'b1;
            outval_d = ra;
          end
          tac_pkg::OPC_IN: begin
            regs_d[dd] = io_q;
            intk_d     = 1'b1;
          end
          tac_pkg::OPC_BEQ: begin
            if (z_q) pc_d = ra;
          end
          tac_pkg::OPC_JUMP: pc_d = ra;
          default: status_d = tac_pkg::ST_BADOP;
        endcase
      end
    end
  end

  assign stat_o.need_mem = need_mem;
  assign res_o           = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) regs_q[i] <= '0;
      pc_q     <= '0;
      z_q      <= 1'b0;
      v_q      <= 1'b0;
      halted_q <= 1'b0;
    end else if (cmd_i.commit_ex) begin
      regs_q   <= regs_d;
      pc_q     <= pc_d;
      z_q      <= z_d;
      v_q      <= v_d;
      halted_q <= halted_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_vld_q <= '0;
      data_vld_q <= '0;
    end else begin
      if (cmd_i.prog_we && wa_ok) prog_vld_q[wa] <= 1'b1;
      if (cmd_i.commit_ex && dwe_d) data_vld_q[da] <= 1'b1;
    end
  end

  // program store: write port for write items, read port for fetch
  always_ff @(posedge clk_i) begin
    if (cmd_i.prog_we && wa_ok) prog_mem[wa] <= in_data_i.prog_data;
    if (cmd_i.fetch) begin
      ins_q <= prog_vld_q[fa] ? prog_mem[fa] : '0;
      io_q  <= in_data_i.io_in;
    end
  end

  // data store
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_ex && dwe_d) data_mem[da] <= regs_q[0];
    if (cmd_i.mem_rd) ld_q <= data_vld_q[da] ? data_mem[da] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_ex) begin
      res_q.status        <= status_d;
      res_q.next_pc       <= pc_d;
      res_q.zero_flag     <= z_d;
      res_q.overflow_flag <= v_d;
      res_q.out_valid     <= outv_d;
      res_q.out_value     <= outval_d;
      res_q.in_taken      <= intk_d;
    end else if (cmd_i.commit_wr) begin
      res_q.status        <= tac_pkg::ST_OK;
      res_q.next_pc       <= pc_q;
      res_q.zero_flag     <= z_q;
      res_q.overflow_flag <= v_q;
      res_q.out_valid     <= 1'b0;
      res_q.out_value     <= '0;
      res_q.in_taken      <= 1'b0;
    end
  end

endmodule

>>> design/tac_checker.sv
`include "tiny_accumulator_cpu_step_macros.svh"

module tac_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input tac_pkg::out_item_t out_data_o
);

  // a stalled result holds
  `TAC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "result changed under stall")

  // core is busy the cycle after any input transfer
  `TAC_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input taken twice back to back")

  // a fresh result only comes from an item in flight
  `TAC_ASSERT_SAME(a_res_from_item, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o), "result without an item in flight")

endmodule

bind tiny_accumulator_cpu_step tac_checker u_tac_checker (.*);

>>> tb/tiny_accumulator_cpu_step_tb.sv
module tiny_accumulator_cpu_step_tb;
  import tac_pkg::*;

  // Two copies of the CPU state: one follows the transfers the block
  // actually takes and produces the expected results, the other is run
  // ahead by the stimulus generator so it can steer programs away from
  // a halt until the very end of the run.
  localparam int MIRROR = 0;
  localparam int PLAN   = 1;

  // Random programs stay below this pc; at it a short return sequence
  // (immediate, then jump through r0) brings the pc back to the bottom.
  localparam logic [7:0] SAFE_TOP = 8'd118;

  localparam int RANDOM_ITEMS = 1600;
  localparam int DRAIN_EVERY  = 300;
  localparam int HOLD_CYCLES  = 90;
  localparam int SETTLE       = 20;
  localparam int CYCLE_LIMIT  = 400000;

  // Result counts at which the receiver starts a long hold.
  localparam int HOLD_AT [2] = '{400, 1100};

  // Opcodes the core does not decode.
  localparam logic [3:0] OPC_UNDEF [3] = '{4'h1, 4'h3, 4'hB};

  // Opening program: every operation but load, move and jump, carry out of add,
  // signed overflow of subtract, and a taken branch back to address 0.
  localparam logic [7:0] WARMUP_PROG [11] = '{
    {OPC_IMM,   4'hF},
    {OPC_IN,    2'd1, 2'd0},
    {OPC_ADD,   2'd1, 2'd0},
    {OPC_IN,    2'd2, 2'd0},
    {OPC_SUB,   2'd2, 2'd1},
    {OPC_SHL,   2'd2, 2'd0},
    {OPC_SHR,   2'd1, 2'd0},
    {OPC_STORE, 2'd0, 2'd0},
    {OPC_TEST,  2'd1, 2'd0},
    {OPC_OUT,   2'd2, 2'd0},
    {OPC_BEQ,   2'd1, 2'd0}
  };
  localparam logic [7:0] WARMUP_IO [11] = '{
    8'h00, 8'hFF, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic     wait_drain;  // hold this item back until nothing is outstanding
    in_item_t payload;
  } queued_item_t;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // CPU state copies, indexed by MIRROR / PLAN
  logic [7:0] cpu_pc   [2];
  logic [7:0] cpu_reg  [2][4];
  logic       cpu_zero [2];
  logic       cpu_ovf  [2];
  logic       cpu_halt [2];
  logic [7:0] cpu_prog [2][PROG_DEPTH];
  logic [7:0] cpu_data [2][DATA_DEPTH];

  queued_item_t cpu_items_q[$];
  out_item_t    cpu_results_due[$];

  int          total_items  = 0;
  int          items_taken  = 0;
  int          results_seen = 0;
  int          mismatches   = 0;
  int          send_gap     = 0;
  int          stall_left   = 0;
  int          hold_left    = 0;
  int          hold_mark    = 0;
  int unsigned cycle_count  = 0;
  logic        drain_next   = 1'b0;

  tiny_accumulator_cpu_step uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #4 clk_i = ~clk_i;

  // One item through copy k of the CPU; returns the result it must cause.
  function automatic out_item_t cpu_step(input int k, input in_item_t it);
    out_item_t  res;
    logic [7:0] ins;
    logic [7:0] rd;
    logic [7:0] ry;
    logic [1:0] d;
    logic [1:0] y;
    logic [8:0] wide;
    res = '0;
    res.status = ST_OK;
    if (it.op == OP_WRITE) begin
      cpu_prog[k][it.prog_address] = it.prog_data;
    end else if (cpu_halt[k]) begin
      res.status = ST_HALT;
    end else if (cpu_pc[k] >= PROG_DEPTH) begin
      cpu_halt[k] = 1'b1;
      res.status = ST_HALT;
    end else begin
      ins = cpu_prog[k][cpu_pc[k]];
      d = ins[3:2];
      y = ins[1:0];
      rd = cpu_reg[k][d];
      ry = cpu_reg[k][y];
      cpu_pc[k] = cpu_pc[k] + 8'd1;
      if (ins == HALT_BYTE) begin
        cpu_halt[k] = 1'b1;
        res.status = ST_HALT;
      end else begin
        case (ins[7:4])
          OPC_LOAD: begin
            if (rd >= DATA_DEPTH) begin
              res.status = ST_ADDR;
            end else begin
              cpu_reg[k][0] = cpu_data[k][rd];
              cpu_zero[k] = (cpu_reg[k][0] == 8'd0);
            end
          end
          OPC_STORE: begin
            if (rd >= DATA_DEPTH) begin
              res.status = ST_ADDR;
            end else begin
              cpu_data[k][rd] = cpu_reg[k][0];
              cpu_zero[k] = (cpu_reg[k][0] == 8'd0);
            end
          end
          OPC_MOVE: begin
            cpu_reg[k][y] = rd;
            cpu_zero[k] = (rd == 8'd0);
          end
          OPC_IMM: begin
            cpu_reg[k][0] = {4'h0, ins[3:0]};
            cpu_zero[k] = (ins[3:0] == 4'h0);
          end
          OPC_ADD: begin
            wide = {1'b0, rd} + {1'b0, ry};
            cpu_ovf[k] = wide[8];
            cpu_reg[k][d] = wide[7:0];
            cpu_zero[k] = (wide[7:0] == 8'd0);
          end
          OPC_SUB: begin
            // 9-bit signed difference always fits; overflow when the
            // top two bits disagree
            wide = {rd[7], rd} - {ry[7], ry};
            cpu_ovf[k] = wide[8] ^ wide[7];
            cpu_reg[k][d] = wide[7:0];
            cpu_zero[k] = (wide[7:0] == 8'd0);
          end
          OPC_SHL: cpu_reg[k][d] = {rd[3:0], 4'h0};
          OPC_SHR: cpu_reg[k][d] = {4'h0, rd[7:4]};
          OPC_TEST: cpu_zero[k] = (rd == 8'd0);
          OPC_OUT: begin
            res.out_valid = 1'b1;
            res.out_value = rd;
          end
          OPC_IN: begin
            cpu_reg[k][d] = it.io_in;
            res.in_taken = 1'b1;
          end
          OPC_BEQ: if (cpu_zero[k]) cpu_pc[k] = rd;
          OPC_JUMP: cpu_pc[k] = rd;
          default: res.status = ST_BADOP;
        endcase
      end
    end
    res.next_pc = cpu_pc[k];
    res.zero_flag = cpu_zero[k];
    res.overflow_flag = cpu_ovf[k];
    return res;
  endfunction

  // Would the planned core survive this byte at its current pc without
  // halting or leaving the low program area?
  function automatic bit plan_safe(input logic [7:0] ins);
    logic [7:0] target;
    target = cpu_reg[PLAN][ins[3:2]];
    if (ins == HALT_BYTE) return 1'b0;
    if (ins[7:4] == OPC_JUMP || (ins[7:4] == OPC_BEQ && cpu_zero[PLAN]))
      return target < SAFE_TOP;
    return 1'b1;
  endfunction

  // Mostly small values so loads, stores and jumps land in range.
  function automatic logic [7:0] pick_io();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 15));
      1: return 8'($urandom_range(0, 117));
      2: return 8'($urandom);
      default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    endcase
  endfunction

  // Idle/stall length per transfer; phases with none, full range, or rare.
  function automatic int draw_wait(input int phase);
    case (phase % 3)
      0: return 0;
      1: return $urandom_range(0, 12);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    endcase
  endfunction

  task automatic queue_item(input logic op, input logic [6:0] addr,
                            input logic [7:0] data, input logic [7:0] io);
    in_item_t it;
    it.op = op;
    it.prog_address = addr;
    it.prog_data = data;
    it.io_in = io;
    void'(cpu_step(PLAN, it));
    cpu_items_q.push_back({drain_next, it});
    drain_next = 1'b0;
    total_items++;
  endtask

  task automatic queue_write(input logic [6:0] addr, input logic [7:0] data);
    queue_item(OP_WRITE, addr, data, 8'($urandom));
  endtask

  task automatic queue_exec(input logic [7:0] io);
    queue_item(OP_EXEC, 7'($urandom), 8'($urandom), io);
  endtask

  // Place an instruction at the planned pc, then run it.
  task automatic run_byte(input logic [7:0] ins, input logic [7:0] io);
    queue_write(cpu_pc[PLAN][6:0], ins);
    queue_exec(io);
  endtask

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Driver: predicts each input transfer, then offers the next queued item
  // after its drawn gap. An item marked wait_drain is held back until every
  // result owed so far has been received.
  always @(posedge clk_i or negedge rst_ni) begin : driver
    int           taken_now;
    queued_item_t next_item;
    if (!rst_ni) begin
      in_valid    <= 1'b0;
      in_data     <= '0;
      send_gap    <= 0;
      items_taken <= 0;
    end else begin
      taken_now = items_taken;
      if (in_valid && !in_stall) begin
        cpu_results_due.push_back(cpu_step(MIRROR, in_data));
        taken_now++;
      end
      items_taken <= taken_now;
      // a stalled item stays put, valid included
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (cpu_items_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (cpu_items_q[0].wait_drain && taken_now != results_seen) begin
          in_valid <= 1'b0;
        end else begin
          next_item = cpu_items_q.pop_front();
          in_valid <= 1'b1;
          in_data  <= next_item.payload;
          send_gap <= draw_wait(taken_now / 150);
        end
      end
    end
  end

  // Long receiver hold: twice in the run, once the result count reaches a
  // mark, the output stays stalled until a countdown from HOLD_CYCLES ends,
  // so the core backs up and stalls its input.
  always @(posedge clk_i or negedge rst_ni) begin : receiver_hold
    if (!rst_ni) begin
      hold_left <= 0;
      hold_mark <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_mark < 2 && results_seen >= HOLD_AT[hold_mark]) begin
      hold_left <= HOLD_CYCLES;
      hold_mark <= hold_mark + 1;
    end
  end

  // Monitor: checks each output transfer against the oldest expectation and
  // drives the output stall, held high throughout a long receiver hold.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    int        seen_now;
    out_item_t want;
    if (!rst_ni) begin
      out_stall    <= 1'b0;
      results_seen <= 0;
    end else begin
      seen_now = results_seen;
      if (out_valid && !out_stall) begin
        seen_now++;
        if (cpu_results_due.size() == 0) begin
          $display("%0t: result %h with no expectation waiting", $time, out_data);
          mismatches++;
        end else begin
          want = cpu_results_due.pop_front();
          check_field("status", 8'(want.status), 8'(out_data.status));
          check_field("next_pc", want.next_pc, out_data.next_pc);
          check_field("zero_flag", 8'(want.zero_flag), 8'(out_data.zero_flag));
          check_field("overflow_flag", 8'(want.overflow_flag), 8'(out_data.overflow_flag));
          check_field("out_valid", 8'(want.out_valid), 8'(out_data.out_valid));
          check_field("out_value", want.out_value, out_data.out_value);
          check_field("in_taken", 8'(want.in_taken), 8'(out_data.in_taken));
        end
        stall_left = draw_wait(seen_now / 170);
      end
      results_seen <= seen_now;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tiny_accumulator_cpu_step verification failed");
      $finish;
    end
  end

  initial begin : sequencer
    int         i;
    int         tries;
    int         roll;
    int         next_drain;
    logic [7:0] ins;

    for (i = 0; i < 2; i++) begin
      cpu_pc[i]   = 8'd0;
      cpu_zero[i] = 1'b0;
      cpu_ovf[i]  = 1'b0;
      cpu_halt[i] = 1'b0;
      for (int r = 0; r < 4; r++) cpu_reg[i][r] = 8'd0;
      for (int a = 0; a < PROG_DEPTH; a++) cpu_prog[i][a] = 8'd0;
      for (int a = 0; a < DATA_DEPTH; a++) cpu_data[i][a] = 8'd0;
    end

    // Directed: run the cleared program byte at 0 (a load of data[0]), the
    // opening program, then an undefined opcode at 0 after the branch.
    queue_exec(pick_io());
    for (i = 0; i < 11; i++) run_byte(WARMUP_PROG[i], WARMUP_IO[i]);
    run_byte({OPC_UNDEF[$urandom_range(0, 2)], 4'($urandom)}, pick_io());

    // Random programs: mostly write-then-run at the current pc, some runs of
    // whatever byte is already there, some stray program writes. Now and
    // then the sender waits for the core to drain completely.
    next_drain = DRAIN_EVERY;
    while (total_items < RANDOM_ITEMS) begin
      if (total_items >= next_drain) begin
        drain_next = 1'b1;
        next_drain += DRAIN_EVERY;
      end
      if (cpu_pc[PLAN] >= SAFE_TOP) begin
        run_byte({OPC_IMM, 4'($urandom)}, pick_io());
        run_byte({OPC_JUMP, 2'd0, 2'd0}, pick_io());
      end else begin
        roll = $urandom_range(0, 99);
        ins = cpu_prog[PLAN][cpu_pc[PLAN]];
        if (roll < 8) begin
          queue_write(7'($urandom), 8'($urandom));
        end else if (roll < 18 && plan_safe(ins)) begin
          queue_exec(pick_io());
        end else begin
          ins = 8'($urandom);
          tries = 0;
          while (!plan_safe(ins) && tries < 8) begin
            ins = 8'($urandom);
            tries++;
          end
          if (!plan_safe(ins)) ins = {OPC_IMM, 4'($urandom)};
          run_byte(ins, pick_io());
        end
      end
    end

    // Halt last, since only reset leaves it: either a halt byte or a jump
    // past the program store. Then executes report halted, and a program
    // write does not wake the core.
    drain_next = 1'b1;
    if ($urandom_range(0, 1)) begin
      run_byte(HALT_BYTE, pick_io());
    end else begin
      run_byte({OPC_IMM, 4'h8}, pick_io());
      run_byte({OPC_SHL, 2'd0, 2'd0}, pick_io());
      run_byte({OPC_JUMP, 2'd0, 2'd0}, pick_io());
      queue_exec(pick_io());
    end
    queue_exec(pick_io());
    queue_write(7'($urandom), 8'($urandom));
    queue_exec(pick_io());

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_taken != total_items || results_seen != total_items) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    if (cpu_results_due.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, cpu_results_due.size());
    if (mismatches == 0 && cpu_results_due.size() == 0) begin
      $display("tiny_accumulator_cpu_step verification clean");
    end else begin
      $display("tiny_accumulator_cpu_step verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/tac_pkg.sv
design/tac_ctrl.sv
design/tac_dp.sv
design/tiny_accumulator_cpu_step.sv
design/tac_checker.sv
tb/tiny_accumulator_cpu_step_tb.sv
